FILE: hw/rtl/obrfe_pkg.sv
// ----------------------------------------------------------------------------
// obrfe_pkg: shared types and constants for the byte ring frame extractor
// Holds the ring depth, register indexes, operation and status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package obrfe_pkg;

  localparam int Depth = 256;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW = AddrW + 1;
  localparam int MaxElements = 16;
  localparam int MaxHeader = 4;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_EXTRACT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOFRAME  = 2'd2,
    ST_BADSUM   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CAPACITY   = 3'd0,
    REG_HDR_BYTES  = 3'd1,
    REG_HDR_LEN    = 3'd2,
    REG_CHECKED    = 3'd3,
    REG_ELEM_WIDTH = 3'd4,
    REG_LOW_FIRST  = 3'd5,
    REG_ELEM_COUNT = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_OUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DATA_RD,
    S_DATA_ACC,
    S_SUM_RD,
    S_SUM_CMP,
    S_EMIT,
    S_FAIL
  } state_t;

endpackage

FILE: hw/rtl/obrfe_ram.sv
// ----------------------------------------------------------------------------
// obrfe_ram: generic single-port RAM
// Per cycle one optional write and one read; the read data is registered.
// ----------------------------------------------------------------------------
module obrfe_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Optional write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/overwriting_byte_ring_frame_extractor_unit.sv
// ----------------------------------------------------------------------------
// overwriting_byte_ring_frame_extractor_unit: byte ring with frame extraction
// Top level: configuration registers, ring pointers, sequencer and output.
// ----------------------------------------------------------------------------
// A push shows its result from S_PUSH, a pop from S_POP_OUT after a read in
// S_POP_RD when the ring is not empty, both bound by the single port of the
// byte RAM. An extract reads the ring a byte at a time through that port:
// the header search compares each header byte in S_SCAN_RD and S_SCAN_CMP
// (a failed candidate restarts one byte further on), then the data bytes
// and, if checked, the sum byte are read; S_EMIT emits one element per
// cycle unless the output stalls. The input stalls until all results of an
// item are taken. Writing the capacity register empties the ring.
module overwriting_byte_ring_frame_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [8:0]  out_fill_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = obrfe_pkg::AddrW;
  localparam int CW = obrfe_pkg::CntW;

  // Configuration registers.
  logic [8:0]  cap_r;
  logic [31:0] hdr_r;
  logic [2:0]  hlen_r;
  logic        chk_r, lbf_r;
  logic [1:0]  ew_r;
  logic [4:0]  ecnt_r;

  // Ring state and sequencer registers.
  obrfe_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] old_r, old_nxt, wr_r, wr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cand_r, cand_nxt;   // candidate header offset
  logic [CW-1:0] off_r, off_nxt;     // byte offset being read
  logic [2:0]    hj_r, hj_nxt;       // header byte index
  logic [2:0]    bj_r, bj_nxt;       // byte within element
  logic [4:0]    ek_r, ek_nxt;       // element index
  logic [7:0]    sum_r, sum_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [1:0]    sts_r, sts_nxt;
  logic [31:0]   elem_r [obrfe_pkg::MaxElements];
  logic          elem_we;

  // Output register.
  logic          ov_r, ov_nxt;
  logic [31:0]   oval_r, oval_nxt;
  logic [1:0]    osts_r, osts_nxt;
  logic          olast_r, olast_nxt;
  logic [8:0]    ofill_r, ofill_nxt;

  // RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  // Effective configuration values.
  logic [CW-1:0] ring;
  logic [2:0]    hl;
  logic [4:0]    ne;
  logic [2:0]    nb;
  logic          chk;
  logic [CW+6:0] need;

  always_comb begin
    if (cap_r == 9'd0) ring = CW'(1);
    else if ({1'b0, cap_r} > 10'(obrfe_pkg::Depth)) ring = CW'(obrfe_pkg::Depth);
    else ring = CW'(cap_r);
    if (hlen_r == 3'd0) hl = 3'd1;
    else if (hlen_r > 3'(obrfe_pkg::MaxHeader)) hl = 3'(obrfe_pkg::MaxHeader);
    else hl = hlen_r;
    if (ecnt_r == 5'd0) ne = 5'd1;
    else if (ecnt_r > 5'(obrfe_pkg::MaxElements)) ne = 5'(obrfe_pkg::MaxElements);
    else ne = ecnt_r;
    chk = chk_r;
    if (!chk_r) nb = 3'd1;
    else if (ew_r == 2'd0) nb = 3'd1;
    else if (ew_r == 2'd1) nb = 3'd2;
    else nb = 3'd4;
    // Ring offset just past a frame whose header starts at offset cand_r.
    need = (CW+7)'(cand_r) + (CW+7)'(hl) + (CW+7)'(ne) * (CW+7)'(nb) + (CW+7)'(chk);
  end

  obrfe_ram #(.Width(8), .Depth(obrfe_pkg::Depth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_byte_in),
    .rdata (ram_rdata)
  );

  // Physical address of ring offset off_r (the sum of oldest position and
  // offset, below twice the ring size, is folded with one compare and subtract).
  logic [CW:0] pos_sum;
  logic [CW:0] pos_mod;
  always_comb begin
    pos_sum = (CW+1)'(old_r) + (CW+1)'(off_r);
    pos_mod = (pos_sum >= (CW+1)'(ring)) ? pos_sum - (CW+1)'(ring) : pos_sum;
  end

  logic [7:0] hbyte;
  always_comb begin
    hbyte = hdr_r[8*hj_r[1:0] +: 8];
  end

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != obrfe_pkg::S_IDLE) || ov_r;
  assign cfg_ready = 1'b1;

  logic out_take;
  assign out_take = ov_r && !out_stall;

  logic [AW-1:0] wr_inc, old_inc;
  always_comb begin
    wr_inc  = ({1'b0, wr_r} + CW'(1) >= ring) ? '0 : wr_r + AW'(1);
    old_inc = ({1'b0, old_r} + CW'(1) >= ring) ? '0 : old_r + AW'(1);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      obrfe_pkg::S_IDLE: begin
        if (accept) begin
          unique case (obrfe_pkg::kind_t'(in_kind))
            obrfe_pkg::KIND_PUSH: state_nxt = obrfe_pkg::S_PUSH;
            obrfe_pkg::KIND_POP:
              state_nxt = (cnt_r == '0) ? obrfe_pkg::S_POP_OUT : obrfe_pkg::S_POP_RD;
            obrfe_pkg::KIND_EXTRACT: state_nxt = obrfe_pkg::S_SCAN_RD;
            obrfe_pkg::KIND_NONE: state_nxt = obrfe_pkg::S_IDLE;
          endcase
        end
      end
      obrfe_pkg::S_PUSH: state_nxt = obrfe_pkg::S_IDLE;
      obrfe_pkg::S_POP_RD: state_nxt = obrfe_pkg::S_POP_OUT;
      obrfe_pkg::S_POP_OUT: state_nxt = obrfe_pkg::S_IDLE;
      obrfe_pkg::S_SCAN_RD: begin
        if ((CW+1)'(cand_r) + (CW+1)'(hl) > (CW+1)'(cnt_r)) state_nxt = obrfe_pkg::S_FAIL;
        else state_nxt = obrfe_pkg::S_SCAN_CMP;
      end
      obrfe_pkg::S_SCAN_CMP: begin
        if (ram_rdata != hbyte) state_nxt = obrfe_pkg::S_SCAN_RD;
        else if (hj_r + 3'd1 == hl) begin
          state_nxt = (need > (CW+7)'(cnt_r)) ? obrfe_pkg::S_FAIL : obrfe_pkg::S_DATA_RD;
        end else state_nxt = obrfe_pkg::S_SCAN_RD;
      end
      obrfe_pkg::S_DATA_RD: state_nxt = obrfe_pkg::S_DATA_ACC;
      obrfe_pkg::S_DATA_ACC: begin
        if (bj_r + 3'd1 == nb && ek_r + 5'd1 == ne)
          state_nxt = chk ? obrfe_pkg::S_SUM_RD : obrfe_pkg::S_EMIT;
        else state_nxt = obrfe_pkg::S_DATA_RD;
      end
      obrfe_pkg::S_SUM_RD: state_nxt = obrfe_pkg::S_SUM_CMP;
      obrfe_pkg::S_SUM_CMP: state_nxt = obrfe_pkg::S_EMIT;
      obrfe_pkg::S_EMIT: begin
        if (!ov_r || out_take) begin
          if (ek_r + 5'd1 == ne) state_nxt = obrfe_pkg::S_IDLE;
        end
      end
      obrfe_pkg::S_FAIL: state_nxt = obrfe_pkg::S_IDLE;
      default: state_nxt = obrfe_pkg::S_IDLE;
    endcase
  end

  // Datapath and output control.
  logic [31:0] acc_shift;
  always_comb begin
    old_nxt = old_r; wr_nxt = wr_r; cnt_nxt = cnt_r;
    cand_nxt = cand_r; off_nxt = off_r; hj_nxt = hj_r; bj_nxt = bj_r; ek_nxt = ek_r;
    sum_nxt = sum_r; acc_nxt = acc_r; sts_nxt = sts_r;
    ov_nxt = out_take ? 1'b0 : ov_r;
    oval_nxt = oval_r; osts_nxt = osts_r; olast_nxt = olast_r; ofill_nxt = ofill_r;
    ram_we = 1'b0;
    ram_addr = AW'(pos_mod);
    elem_we = 1'b0;
    if (lbf_r) acc_shift = acc_r | ({24'd0, ram_rdata} << (8 * bj_r[1:0]));
    else acc_shift = {acc_r[23:0], ram_rdata};
    unique case (state_r)
      obrfe_pkg::S_IDLE: begin
        if (accept) begin
          ram_addr = wr_r;
          off_nxt = '0; cand_nxt = '0; hj_nxt = '0; bj_nxt = '0; ek_nxt = '0;
          acc_nxt = '0; sum_nxt = '0; sts_nxt = obrfe_pkg::ST_OK;
          if (obrfe_pkg::kind_t'(in_kind) == obrfe_pkg::KIND_PUSH) ram_we = 1'b1;
        end
      end
      obrfe_pkg::S_PUSH: begin
        wr_nxt = wr_inc;
        if (cnt_r >= ring) old_nxt = old_inc;
        else cnt_nxt = cnt_r + CW'(1);
        ov_nxt = 1'b1; oval_nxt = '0; osts_nxt = obrfe_pkg::ST_OK; olast_nxt = 1'b1;
        ofill_nxt = (cnt_r >= ring) ? 9'(cnt_r) : 9'(cnt_r + CW'(1));
      end
      obrfe_pkg::S_POP_RD: begin
      end
      obrfe_pkg::S_POP_OUT: begin
        ov_nxt = 1'b1; olast_nxt = 1'b1;
        if (cnt_r == '0) begin
          oval_nxt = '0; osts_nxt = obrfe_pkg::ST_EMPTY; ofill_nxt = '0;
        end else begin
          oval_nxt = {24'd0, ram_rdata}; osts_nxt = obrfe_pkg::ST_OK;
          old_nxt = old_inc; cnt_nxt = cnt_r - CW'(1);
          ofill_nxt = 9'(cnt_r - CW'(1));
        end
      end
      obrfe_pkg::S_SCAN_RD: begin
      end
      obrfe_pkg::S_SCAN_CMP: begin
        if (ram_rdata != hbyte) begin
          cand_nxt = cand_r + CW'(1); off_nxt = cand_r + CW'(1);
          hj_nxt = '0; sum_nxt = '0;
        end else begin
          sum_nxt = sum_r + ram_rdata;
          off_nxt = off_r + CW'(1);
          hj_nxt = hj_r + 3'd1;
        end
      end
      obrfe_pkg::S_DATA_RD: begin
      end
      obrfe_pkg::S_DATA_ACC: begin
        sum_nxt = sum_r + ram_rdata;
        off_nxt = off_r + CW'(1);
        if (bj_r + 3'd1 == nb) begin
          elem_we = 1'b1;
          acc_nxt = '0; bj_nxt = '0;
          if (ek_r + 5'd1 != ne) ek_nxt = ek_r + 5'd1;
          else ek_nxt = '0;
        end else begin
          acc_nxt = acc_shift; bj_nxt = bj_r + 3'd1;
        end
      end
      obrfe_pkg::S_SUM_RD: begin
      end
      obrfe_pkg::S_SUM_CMP: begin
        off_nxt = off_r + CW'(1);
        if (ram_rdata != sum_r) sts_nxt = obrfe_pkg::ST_BADSUM;
      end
      obrfe_pkg::S_EMIT: begin
        if (!ov_r || out_take) begin
          ov_nxt = 1'b1;
          oval_nxt = elem_r[ek_r[3:0]];
          osts_nxt = sts_r;
          olast_nxt = (ek_r + 5'd1 == ne);
          ofill_nxt = 9'(cnt_r - cand_r - CW'(hl) - CW'(ek_r + 5'd1) * CW'(nb)
                         - ((ek_r + 5'd1 == ne) ? CW'(chk) : CW'(0)));
          ek_nxt = ek_r + 5'd1;
          if (ek_r + 5'd1 == ne) begin
            // Consume everything through the frame.
            old_nxt = AW'(pos_mod);
            cnt_nxt = cnt_r - off_r;
          end
        end
      end
      obrfe_pkg::S_FAIL: begin
        ov_nxt = 1'b1; oval_nxt = '0; osts_nxt = obrfe_pkg::ST_NOFRAME;
        olast_nxt = 1'b1; ofill_nxt = 9'(cnt_r);
      end
      default: begin
      end
    endcase
    // Writing the capacity register empties the ring.
    if (cfg_valid && cfg_ready &&
        obrfe_pkg::reg_idx_t'(cfg_index) == obrfe_pkg::REG_CAPACITY) begin
      old_nxt = '0; wr_nxt = '0; cnt_nxt = '0;
    end
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obrfe_pkg::S_IDLE;
      old_r <= '0; wr_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
      cap_r <= 9'd256; hdr_r <= '0; hlen_r <= 3'd1; chk_r <= 1'b1;
      ew_r <= 2'd0; lbf_r <= 1'b1; ecnt_r <= 5'd1;
    end else begin
      state_r <= state_nxt;
      old_r <= old_nxt; wr_r <= wr_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (obrfe_pkg::reg_idx_t'(cfg_index))
          obrfe_pkg::REG_CAPACITY:   cap_r <= cfg_data[8:0];
          obrfe_pkg::REG_HDR_BYTES:  hdr_r <= cfg_data;
          obrfe_pkg::REG_HDR_LEN:    hlen_r <= cfg_data[2:0];
          obrfe_pkg::REG_CHECKED:    chk_r <= cfg_data[0];
          obrfe_pkg::REG_ELEM_WIDTH: ew_r <= cfg_data[1:0];
          obrfe_pkg::REG_LOW_FIRST:  lbf_r <= cfg_data[0];
          obrfe_pkg::REG_ELEM_COUNT: ecnt_r <= cfg_data[4:0];
          obrfe_pkg::REG_UNUSED: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt; off_r <= off_nxt; hj_r <= hj_nxt; bj_r <= bj_nxt;
    ek_r <= ek_nxt; sum_r <= sum_nxt; acc_r <= acc_nxt; sts_r <= sts_nxt;
    oval_r <= oval_nxt; osts_r <= osts_nxt; olast_r <= olast_nxt; ofill_r <= ofill_nxt;
    if (elem_we) elem_r[ek_r[3:0]] <= acc_shift;
  end

  assign out_valid = ov_r;
  assign out_value = oval_r;
  assign out_status = osts_r;
  assign out_last = olast_r;
  assign out_fill_level = ofill_r;

endmodule
